/* hdl/surs_pkg.sv */
`default_nettype none

package surs_pkg;

   // Sequencer states of the segmenter.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN,
      ST_UPDATE
   } fsm_state_type;

   // Item kinds on the request channel.
   localparam logic FUNC_MAP_WRITE  = 1'b0;
   localparam logic FUNC_SCAN_POINT = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MIN_WIDTH   = 2'd2;

   // Configuration reset values.
   localparam logic [8:0]  GRID_WIDTH_RESET  = 9'd256;
   localparam logic [8:0]  GRID_HEIGHT_RESET = 9'd256;
   localparam logic [10:0] MIN_WIDTH_RESET   = 11'd3;

   // Map value that marks a cell occupied.
   localparam logic signed [7:0] OCCUPIED_VALUE = 8'sd100;

endpackage

`default_nettype wire

/* hdl/surs_ram.sv */
`default_nettype none

module surs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // One read port with registered data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/scan_unexpected_run_segmenter.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  func, x_cell, y_cell, cell_value,
//                                           point_valid, last_point
// rsp       out        rsp_valid/rsp_ready  seg_valid, seg_start, seg_end, seg_wide,
//                                           scan_done, obstacle_detected
// csr       in         csr_valid/csr_ready  index, wdata (always ready)
//
// A map write leaves the block in idle, ready for the next transfer.
// A valid scan point is accepted, then its window cells are read one by one on
// the single map read port, followed by a read drain state and then the update
// state.
// An invalid scan point skips the window search and goes from the accept
// straight to the update state.
// After reset a clearing pass writes every map cell free, with req_ready low;
// csr writes are taken.
// A result waits in the output register while the next item is taken; a point
// that needs a result finishes only once that register is free.

`default_nettype none

module scan_unexpected_run_segmenter #(
   parameter int GRID_SIDE      = 256,
   parameter int MAX_POINTS     = 1024,
   parameter int NEIGHBOR_RANGE = 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_func,
   input  wire logic signed [10:0] req_x_cell,
   input  wire logic signed [10:0] req_y_cell,
   input  wire logic signed [7:0]  req_cell_value,
   input  wire logic               req_point_valid,
   input  wire logic               req_last_point,
   // Result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_seg_valid,
   output logic [9:0]              rsp_seg_start,
   output logic [9:0]              rsp_seg_end,
   output logic                    rsp_seg_wide,
   output logic                    rsp_scan_done,
   output logic                    rsp_obstacle_detected,
   // Configuration channel
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [10:0]        csr_wdata
);

   localparam int WIN   = 2 * NEIGHBOR_RANGE + 2;
   localparam int OFF_W = $clog2(WIN);
   localparam int DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int A_W   = $clog2(DEPTH);
   localparam int CW    = $clog2(GRID_SIDE);
   localparam int PC_W  = $clog2(MAX_POINTS);
   localparam int LEN_W = (PC_W + 1 > 11) ? PC_W + 1 : 11;

   // Control state
   surs_pkg::fsm_state_type state_ff, state_in;
   logic [A_W-1:0]   clr_ff, clr_in;
   logic [OFF_W-1:0] dx_ff, dx_in;
   logic [OFF_W-1:0] dy_ff, dy_in;
   logic             rd_ok_ff, rd_ok_in;
   logic             hit_ff, hit_in;
   logic             in_run_ff, in_run_in;
   logic             any_wide_ff, any_wide_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [PC_W-1:0]  first_ff, first_in;
   logic [PC_W-1:0]  last_ff, last_in;
   logic             out_valid_ff, out_valid_in;
   logic [8:0]       gw_ff, gh_ff;
   logic [10:0]      mw_ff;

   // Captured point and result payload
   logic signed [10:0] x_ff, x_in;
   logic signed [10:0] y_ff, y_in;
   logic               pvalid_ff, pvalid_in;
   logic               plast_ff, plast_in;
   logic               o_seg_valid_ff, o_seg_valid_in;
   logic [9:0]         o_start_ff, o_start_in;
   logic [9:0]         o_end_ff, o_end_in;
   logic               o_wide_ff, o_wide_in;
   logic               o_done_ff, o_done_in;
   logic               o_obst_ff, o_obst_in;

   // Map port signals
   logic           ram_we;
   logic [A_W-1:0] ram_waddr;
   logic [0:0]     ram_wdata;
   logic [A_W-1:0] ram_raddr;
   logic [0:0]     ram_rdata;

   // Window address and bounds
   logic [11:0]        eff_w_c, eff_h_c;
   logic signed [11:0] dx_off_c, dy_off_c;
   logic signed [11:0] a_c, b_c;
   logic               rd_inb_c;
   logic               wr_inb_c;
   logic [A_W-1:0]     wr_addr_c;

   // Run decision
   logic             unexp_c;
   logic             close_c;
   logic             need_rsp_c;
   logic [PC_W-1:0]  s_c, e_c;
   logic [LEN_W-1:0] len_c;
   logic             wide_c;
   logic [PC_W-1:0]  pc_next_c;

   surs_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Bounds in use, limited to the map side.
   assign eff_w_c = ({3'b000, gw_ff} > 12'(GRID_SIDE)) ? 12'(GRID_SIDE) : {3'b000, gw_ff};
   assign eff_h_c = ({3'b000, gh_ff} > 12'(GRID_SIDE)) ? 12'(GRID_SIDE) : {3'b000, gh_ff};

   // Window cell under the sequencer, offsets from -(range+1) to +range.
   assign dx_off_c  = $signed(12'(dx_ff) - 12'(NEIGHBOR_RANGE + 1));
   assign dy_off_c  = $signed(12'(dy_ff) - 12'(NEIGHBOR_RANGE + 1));
   assign a_c       = 12'(x_ff) + dx_off_c;
   assign b_c       = 12'(y_ff) + dy_off_c;
   assign rd_inb_c  = !a_c[11] && !b_c[11] &&
                      ($unsigned(a_c) < eff_w_c) && ($unsigned(b_c) < eff_h_c);
   assign ram_raddr = A_W'(A_W'(b_c[CW-1:0]) * A_W'(GRID_SIDE)) + A_W'(a_c[CW-1:0]);

   // Map write address straight from the request.
   assign wr_inb_c  = !req_x_cell[10] && !req_y_cell[10] &&
                      (12'(req_x_cell) < 12'(GRID_SIDE)) &&
                      (12'(req_y_cell) < 12'(GRID_SIDE));
   assign wr_addr_c = A_W'(A_W'(req_y_cell[CW-1:0]) * A_W'(GRID_SIDE)) +
                      A_W'(req_x_cell[CW-1:0]);

   // Run bookkeeping for the point in the update state.
   assign unexp_c    = pvalid_ff && !hit_ff;
   assign close_c    = unexp_c ? plast_ff : in_run_ff;
   assign need_rsp_c = close_c || plast_ff;
   assign s_c        = (unexp_c && !in_run_ff) ? pc_ff : first_ff;
   assign e_c        = unexp_c ? pc_ff : last_ff;
   assign len_c      = LEN_W'(e_c) - LEN_W'(s_c) + LEN_W'(1);
   assign wide_c     = len_c >= LEN_W'(mw_ff);
   assign pc_next_c  = (pc_ff < PC_W'(MAX_POINTS - 1)) ? pc_ff + PC_W'(1) : pc_ff;

   // Sequencer: next state, map port and register updates.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      rd_ok_in       = 1'b0;
      hit_in         = hit_ff | (rd_ok_ff & ram_rdata[0]);
      in_run_in      = in_run_ff;
      any_wide_in    = any_wide_ff;
      pc_in          = pc_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      out_valid_in   = out_valid_ff & ~rsp_ready;
      x_in           = x_ff;
      y_in           = y_ff;
      pvalid_in      = pvalid_ff;
      plast_in       = plast_ff;
      o_seg_valid_in = o_seg_valid_ff;
      o_start_in     = o_start_ff;
      o_end_in       = o_end_ff;
      o_wide_in      = o_wide_ff;
      o_done_in      = o_done_ff;
      o_obst_in      = o_obst_ff;
      ram_we         = 1'b0;
      ram_waddr      = clr_ff;
      ram_wdata      = 1'b0;
      req_ready      = 1'b0;

      case (state_ff)
         surs_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + A_W'(1);
            if (clr_ff == A_W'(DEPTH - 1)) begin
               state_in = surs_pkg::ST_IDLE;
            end
         end
         surs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == surs_pkg::FUNC_MAP_WRITE) begin
                  ram_we    = wr_inb_c;
                  ram_waddr = wr_addr_c;
                  ram_wdata = (req_cell_value == surs_pkg::OCCUPIED_VALUE);
               end else begin
                  x_in      = req_x_cell;
                  y_in      = req_y_cell;
                  pvalid_in = req_point_valid;
                  plast_in  = req_last_point;
                  hit_in    = 1'b0;
                  dx_in     = '0;
                  dy_in     = '0;
                  state_in  = req_point_valid ? surs_pkg::ST_SEARCH : surs_pkg::ST_UPDATE;
               end
            end
         end
         surs_pkg::ST_SEARCH: begin
            // One window cell per cycle through the map read port.
            rd_ok_in = rd_inb_c;
            if (dy_ff == OFF_W'(WIN - 1)) begin
               dy_in = '0;
               dx_in = dx_ff + OFF_W'(1);
               if (dx_ff == OFF_W'(WIN - 1)) begin
                  state_in = surs_pkg::ST_DRAIN;
               end
            end else begin
               dy_in = dy_ff + OFF_W'(1);
            end
         end
         surs_pkg::ST_DRAIN: begin
            state_in = surs_pkg::ST_UPDATE;
         end
         surs_pkg::ST_UPDATE: begin
            if (!(need_rsp_c && out_valid_ff && !rsp_ready)) begin
               state_in = surs_pkg::ST_IDLE;
               if (need_rsp_c) begin
                  out_valid_in   = 1'b1;
                  o_seg_valid_in = close_c;
                  o_start_in     = close_c ? 10'(s_c) : 10'd0;
                  o_end_in       = close_c ? 10'(e_c) : 10'd0;
                  o_wide_in      = close_c && wide_c;
                  o_done_in      = plast_ff;
                  o_obst_in      = plast_ff && (any_wide_ff || (close_c && wide_c));
               end
               if (plast_ff) begin
                  // The last point starts the next scan from scratch.
                  in_run_in   = 1'b0;
                  any_wide_in = 1'b0;
                  pc_in       = '0;
                  first_in    = '0;
                  last_in     = '0;
               end else begin
                  in_run_in   = close_c ? 1'b0 : (unexp_c || in_run_ff);
                  any_wide_in = any_wide_ff || (close_c && wide_c);
                  pc_in       = pc_next_c;
                  if (unexp_c && !in_run_ff) begin
                     first_in = pc_ff;
                  end
                  if (unexp_c) begin
                     last_in = pc_ff;
                  end
               end
            end
         end
         default: begin
            state_in = surs_pkg::ST_CLEAR;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= surs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rd_ok_ff     <= 1'b0;
         in_run_ff    <= 1'b0;
         any_wide_ff  <= 1'b0;
         pc_ff        <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rd_ok_ff     <= rd_ok_in;
         in_run_ff    <= in_run_in;
         any_wide_ff  <= any_wide_in;
         pc_ff        <= pc_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Configuration registers, written on a csr transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= surs_pkg::GRID_WIDTH_RESET;
         gh_ff <= surs_pkg::GRID_HEIGHT_RESET;
         mw_ff <= surs_pkg::MIN_WIDTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            surs_pkg::CSR_GRID_WIDTH: begin
               gw_ff <= csr_wdata[8:0];
            end
            surs_pkg::CSR_GRID_HEIGHT: begin
               gh_ff <= csr_wdata[8:0];
            end
            surs_pkg::CSR_MIN_WIDTH: begin
               mw_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Payload registers: window counters, captured point, result.
   always_ff @(posedge clock) begin
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      hit_ff         <= hit_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      pvalid_ff      <= pvalid_in;
      plast_ff       <= plast_in;
      o_seg_valid_ff <= o_seg_valid_in;
      o_start_ff     <= o_start_in;
      o_end_ff       <= o_end_in;
      o_wide_ff      <= o_wide_in;
      o_done_ff      <= o_done_in;
      o_obst_ff      <= o_obst_in;
   end

   assign csr_ready             = 1'b1;
   assign rsp_valid             = out_valid_ff;
   assign rsp_seg_valid         = o_seg_valid_ff;
   assign rsp_seg_start         = o_start_ff;
   assign rsp_seg_end           = o_end_ff;
   assign rsp_seg_wide          = o_wide_ff;
   assign rsp_scan_done         = o_done_ff;
   assign rsp_obstacle_detected = o_obst_ff;

endmodule

`default_nettype wire

/* hdl/surs_checker.sv */
`default_nettype none

module surs_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               req_func,
   input wire logic signed [10:0] req_x_cell,
   input wire logic signed [10:0] req_y_cell,
   input wire logic signed [7:0]  req_cell_value,
   input wire logic               req_point_valid,
   input wire logic               req_last_point,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_seg_valid,
   input wire logic [9:0]         rsp_seg_start,
   input wire logic [9:0]         rsp_seg_end,
   input wire logic               rsp_seg_wide,
   input wire logic               rsp_scan_done,
   input wire logic               rsp_obstacle_detected,
   input wire logic               csr_valid,
   input wire logic               csr_ready,
   input wire logic [1:0]         csr_index,
   input wire logic [10:0]        csr_wdata
);

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seg_valid) &&
         $stable(rsp_seg_start) && $stable(rsp_seg_end) && $stable(rsp_seg_wide) &&
         $stable(rsp_scan_done) && $stable(rsp_obstacle_detected))
      else $error("stalled result changed");

   // A result that does not end the scan always carries a closed run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_scan_done |-> rsp_seg_valid && !rsp_obstacle_detected)
      else $error("result without run before end of scan");

   // A result with no run has zero run fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_seg_valid |->
         rsp_seg_start == 10'd0 && rsp_seg_end == 10'd0 && !rsp_seg_wide)
      else $error("empty result carries run fields");

   // A scan point, valid or not, makes the block busy, so req_ready drops after the transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == surs_pkg::FUNC_SCAN_POINT |=> !req_ready)
      else $error("ready right after a scan point transfer");

endmodule

bind scan_unexpected_run_segmenter surs_checker u_surs_checker (.*);

`default_nettype wire
